// File: src/priority_aging_task_picker_assert.svh
// Assertion macros shared by the priority aging task picker RTL.
`ifndef PRIORITY_AGING_TASK_PICKER_ASSERT_SVH
`define PRIORITY_AGING_TASK_PICKER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge while reset is released.
`define PATP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define PATP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PATP_ASSERT(lbl, prop, msg)
`define PATP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/patp_pkg.sv
// Shared widths, reset values and register map of the priority aging task picker.
`timescale 1ns / 1ps
package patp_pkg;

	localparam int TASK_W         = 3;
	localparam int PERIOD_W       = 20;
	localparam int PRIO_W         = 8;
	localparam int MAX_TASKS      = 5;
	localparam int CFG_ADDR_W     = 5;
	localparam int CFG_DATA_W     = 32;
	localparam int TASK_COUNT_DEF = 5;
	localparam int AGE_BITS_DEF   = 16;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 20'd500000;
	localparam logic [PRIO_W-1:0]   IDLE_PRIO_RESET = 8'd255;

	// Register index, taken from byte address bits [4:2].
	typedef enum logic [2:0] {
		REG_TICK_PERIOD = 3'd0,
		REG_IDLE_PRIO   = 3'd1,
		REG_TASK1_PRIO  = 3'd2,
		REG_TASK2_PRIO  = 3'd3,
		REG_TASK3_PRIO  = 3'd4,
		REG_TASK4_PRIO  = 3'd5
	} cfg_reg_t;

endpackage

// File: src/patp_tick_if.sv
// Valid/ready channel that carries one timer tick transaction.
`timescale 1ns / 1ps
interface patp_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink   (input valid, input tick, output ready);
endinterface

// File: src/patp_result_if.sv
// Valid/ready channel that carries one dispatch result transaction.
`timescale 1ns / 1ps
interface patp_result_if
	import patp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              dispatched;
	logic [TASK_W-1:0] next_task;
	logic              switched;

	modport source (output valid, output dispatched, output next_task, output switched,
		input ready);
	modport sink   (input valid, input dispatched, input next_task, input switched,
		output ready);
endinterface

// File: src/priority_aging_task_picker.sv
// Timing: a tick with no dispatch goes from ST_IDLE through ST_DONE into the result register.
// A dispatch tick passes through ST_SCAN and then ST_AGE before ST_DONE: one compare per
// task to find the oldest best task, then one saturating increment per task for aging.
// Throughput: one tick at a time; the next tick is taken the cycle after the result enters
// the output register, and a result can wait in ST_DONE while the result side stalls.
// Reset (arst_n low, asynchronous): ages and tick counter zero, idle task running.
`timescale 1ns / 1ps
`include "priority_aging_task_picker_assert.svh"
module priority_aging_task_picker
	import patp_pkg::*;
#(
	parameter int TASK_COUNT = TASK_COUNT_DEF,
	parameter int AGE_BITS   = AGE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	patp_tick_if.sink             tick_ch,
	patp_result_if.source         result_ch
);

	localparam int AGE_N = TASK_COUNT - 1;
	localparam int PTR_W = (AGE_N > 1) ? $clog2(AGE_N) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AGE_N - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_AGE,
		ST_DONE
	} state_t;

	// Configuration registers.
	logic [PERIOD_W-1:0] period_q;
	logic [PRIO_W-1:0]   prio_q [MAX_TASKS];

	// Scheduler state.
	state_t              state_q;
	logic [AGE_BITS-1:0] age_q [AGE_N];
	logic [TASK_W-1:0]   running_q;
	logic [PERIOD_W-1:0] tick_count_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [AGE_BITS-1:0] max_q;
	logic [TASK_W-1:0]   best_q;
	logic [PRIO_W-1:0]   best_prio_q;

	// Pending result and output register.
	logic                res_dispatched_q;
	logic [TASK_W-1:0]   res_next_q;
	logic                res_switched_q;
	logic                out_valid_q;
	logic                out_dispatched_q;
	logic [TASK_W-1:0]   out_next_q;
	logic                out_switched_q;

	logic                cfg_wr;
	cfg_reg_t            cfg_idx;
	logic                in_fire;
	logic [TASK_W-1:0]   ptr_task;
	logic [AGE_BITS-1:0] age_rd;
	logic [PRIO_W-1:0]   prio_rd;
	logic                age_gt;
	logic                age_eq;
	logic                age_sat;
	logic                ptr_last;
	logic [PERIOD_W-1:0] count_inc;
	logic [PERIOD_W-1:0] count_next;
	logic                out_free;

	// Register port: writes complete in the access phase, reads are a plain mux.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = cfg_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			prio_q[0] <= IDLE_PRIO_RESET;
			for (int i = 1; i < MAX_TASKS; i++) begin
				prio_q[i] <= PRIO_W'(i);
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_TICK_PERIOD: period_q  <= pwdata[PERIOD_W-1:0];
				REG_IDLE_PRIO:   prio_q[0] <= pwdata[PRIO_W-1:0];
				REG_TASK1_PRIO:  prio_q[1] <= pwdata[PRIO_W-1:0];
				REG_TASK2_PRIO:  prio_q[2] <= pwdata[PRIO_W-1:0];
				REG_TASK3_PRIO:  prio_q[3] <= pwdata[PRIO_W-1:0];
				REG_TASK4_PRIO:  prio_q[4] <= pwdata[PRIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_TICK_PERIOD: prdata = CFG_DATA_W'(period_q);
			REG_IDLE_PRIO:   prdata = CFG_DATA_W'(prio_q[0]);
			REG_TASK1_PRIO:  prdata = CFG_DATA_W'(prio_q[1]);
			REG_TASK2_PRIO:  prdata = CFG_DATA_W'(prio_q[2]);
			REG_TASK3_PRIO:  prdata = CFG_DATA_W'(prio_q[3]);
			REG_TASK4_PRIO:  prdata = CFG_DATA_W'(prio_q[4]);
			default:         prdata = '0;
		endcase
	end

	// Handshakes.
	assign tick_ch.ready        = (state_q == ST_IDLE);
	assign in_fire              = tick_ch.valid & tick_ch.ready;
	assign out_free             = ~out_valid_q | result_ch.ready;
	assign result_ch.valid      = out_valid_q;
	assign result_ch.dispatched = out_dispatched_q;
	assign result_ch.next_task  = out_next_q;
	assign result_ch.switched   = out_switched_q;

	// Shared compare unit: one task entry per cycle, selected by the pointer.
	assign ptr_task = TASK_W'(ptr_q) + TASK_W'(1);
	assign ptr_last = (ptr_q == PTR_LAST);
	assign age_rd   = age_q[ptr_q];
	assign prio_rd  = prio_q[ptr_task];
	assign age_gt   = (age_rd > max_q);
	assign age_eq   = (age_rd == max_q);
	assign age_sat  = (age_rd == {AGE_BITS{1'b1}});

	// Tick counter advance with wrap at the period; the counter itself wraps at its width.
	assign count_inc  = tick_count_q + PERIOD_W'(1);
	assign count_next = (count_inc >= period_q) ? '0 : count_inc;

	// Sequencer: accept a tick, scan for the best task, age the others, hand over result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			running_q        <= '0;
			tick_count_q     <= '0;
			ptr_q            <= '0;
			max_q            <= '0;
			best_q           <= '0;
			best_prio_q      <= '0;
			res_dispatched_q <= 1'b0;
			res_next_q       <= '0;
			res_switched_q   <= 1'b0;
			out_valid_q      <= 1'b0;
			out_dispatched_q <= 1'b0;
			out_next_q       <= '0;
			out_switched_q   <= 1'b0;
			for (int i = 0; i < AGE_N; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			// The output register empties once its result is taken, unless a new result is loaded this cycle.
			if (out_valid_q && result_ch.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						ptr_q            <= '0;
						max_q            <= '0;
						best_q           <= '0;
						best_prio_q      <= prio_q[0];
						res_dispatched_q <= 1'b0;
						res_next_q       <= running_q;
						res_switched_q   <= 1'b0;
						if (tick_ch.tick) begin
							tick_count_q <= count_next;
							if (tick_count_q == '0) begin
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					// A strictly older task restarts the choice from the idle task.
					if (age_gt) begin
						max_q <= age_rd;
						if (prio_rd <= prio_q[0]) begin
							best_q      <= ptr_task;
							best_prio_q <= prio_rd;
						end else begin
							best_q      <= '0;
							best_prio_q <= prio_q[0];
						end
					end else if (age_eq && (prio_rd <= best_prio_q)) begin
						best_q      <= ptr_task;
						best_prio_q <= prio_rd;
					end
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= ST_AGE;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				ST_AGE: begin
					if ((ptr_task != best_q) && !age_sat) begin
						age_q[ptr_q] <= age_rd + AGE_BITS'(1);
					end
					if (ptr_last) begin
						res_dispatched_q <= 1'b1;
						res_next_q       <= best_q;
						res_switched_q   <= (best_q != running_q);
						running_q        <= best_q;
						state_q          <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_dispatched_q <= res_dispatched_q;
						out_next_q       <= res_next_q;
						out_switched_q   <= res_switched_q;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PATP_ASSERT(a_no_switch_without_dispatch,
		(out_valid_q && !out_dispatched_q) |-> !out_switched_q,
		"switch reported on a tick without dispatch")
	`PATP_ASSERT_ALWAYS(a_running_in_range,
		running_q < TASK_W'(TASK_COUNT),
		"running task outside the task range")
	`PATP_ASSERT(a_ptr_in_range,
		(state_q == ST_SCAN || state_q == ST_AGE) |-> (ptr_q <= PTR_LAST),
		"task pointer past the last task")
	`PATP_ASSERT(a_running_follows_result,
		(state_q == ST_AGE && ptr_last) |=> (running_q == res_next_q && res_dispatched_q),
		"running task does not match the dispatched task")

endmodule

// File: test/priority_aging_task_picker_tb.sv
// Self-checking testbench for the priority aging task picker.
`timescale 1ns / 1ps
module priority_aging_task_picker_tb;
	import patp_pkg::*;

	localparam int          CYCLE_LIMIT = 5_000_000;
	localparam int          AGE_MAX     = (1 << AGE_BITS_DEF) - 1;
	localparam int          PERIOD_MAX  = (1 << PERIOD_W) - 1;
	// Register indexes past the end of the map; writes to them are dropped.
	localparam logic [2:0]  REG_SPARE6  = 3'd6;
	localparam logic [2:0]  REG_SPARE7  = 3'd7;

	typedef struct packed {
		logic              dispatched;
		logic [TASK_W-1:0] next_task;
		logic              switched;
	} pick_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	patp_tick_if   tick_ch ();
	patp_result_if result_ch ();

	priority_aging_task_picker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tick_ch   (tick_ch),
		.result_ch (result_ch)
	);

	// Shadow copy of the scheduler state and its registers.
	logic [PERIOD_W-1:0]     period_cfg;
	logic [PRIO_W-1:0]       prio_cfg [0:MAX_TASKS-1];
	logic [AGE_BITS_DEF-1:0] age_shadow [1:MAX_TASKS-1];
	logic [TASK_W-1:0]       running_shadow;
	logic [PERIOD_W-1:0]     tick_cnt_shadow;

	pick_result_t dispatch_q [$];
	pick_result_t expected_res;
	int           fail_count = 0;
	int           cycle_count = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_off = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Works out the result of one tick and advances the shadow state.
	function automatic pick_result_t predict_tick(input logic tick_in);
		pick_result_t            res;
		logic [AGE_BITS_DEF-1:0] oldest;
		logic [TASK_W-1:0]       best;
		res.dispatched = 1'b0;
		res.next_task  = running_shadow;
		res.switched   = 1'b0;
		if (tick_in) begin
			if (tick_cnt_shadow == '0) begin
				oldest = '0;
				for (int i = 1; i < TASK_COUNT_DEF; i++)
					if (age_shadow[i] >= oldest) oldest = age_shadow[i];
				// Ties go to the later task; idle holds if nobody old enough beats it.
				best = '0;
				for (int i = 1; i < TASK_COUNT_DEF; i++)
					if (age_shadow[i] == oldest && prio_cfg[i] <= prio_cfg[best])
						best = TASK_W'(i);
				for (int i = 1; i < TASK_COUNT_DEF; i++)
					if (i != best && age_shadow[i] != AGE_MAX)
						age_shadow[i] = age_shadow[i] + 1'b1;
				res.dispatched = 1'b1;
				res.next_task  = best;
				res.switched   = (best != running_shadow);
				running_shadow = best;
			end
			tick_cnt_shadow = tick_cnt_shadow + 1'b1;
			if (tick_cnt_shadow >= period_cfg) tick_cnt_shadow = '0;
		end
		return res;
	endfunction

	// Shadow reset values.
	initial begin
		period_cfg      = PERIOD_RESET;
		prio_cfg[0]     = IDLE_PRIO_RESET;
		for (int i = 1; i < MAX_TASKS; i++) begin
			prio_cfg[i]   = PRIO_W'(i);
			age_shadow[i] = '0;
		end
		running_shadow  = '0;
		tick_cnt_shadow = '0;
	end

	// Checks each result transaction, predicts each tick transaction and
	// tracks register writes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (dispatch_q.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					expected_res = dispatch_q.pop_front();
					if (result_ch.dispatched !== expected_res.dispatched) begin
						$error("dispatched: expected %0d, actual %0d",
							expected_res.dispatched, result_ch.dispatched);
						fail_count++;
					end
					if (result_ch.next_task !== expected_res.next_task) begin
						$error("next_task: expected %0d, actual %0d",
							expected_res.next_task, result_ch.next_task);
						fail_count++;
					end
					if (result_ch.switched !== expected_res.switched) begin
						$error("switched: expected %0d, actual %0d",
							expected_res.switched, result_ch.switched);
						fail_count++;
					end
				end
			end
			if (tick_ch.valid && tick_ch.ready)
				dispatch_q.push_back(predict_tick(tick_ch.tick));
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_TICK_PERIOD: period_cfg = pwdata[PERIOD_W-1:0];
					REG_IDLE_PRIO, REG_TASK1_PRIO, REG_TASK2_PRIO, REG_TASK3_PRIO,
					REG_TASK4_PRIO: prio_cfg[paddr[4:2] - 1] = pwdata[PRIO_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offers one tick transaction and waits until it is taken. Valid stays
	// high afterward so that back-to-back transactions need no gap.
	task automatic send_tick(input logic tick_val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.tick  <= tick_val;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	// Stops offering ticks and waits for every expected result.
	task automatic drain;
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (dispatch_q.size() != 0) @(posedge clk);
	endtask

	// One register write: setup cycle, then access cycle.
	task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_prios(input int idle_p, input int p1, input int p2, input int p3,
		input int p4);
		write_reg(REG_IDLE_PRIO, idle_p);
		write_reg(REG_TASK1_PRIO, p1);
		write_reg(REG_TASK2_PRIO, p2);
		write_reg(REG_TASK3_PRIO, p3);
		write_reg(REG_TASK4_PRIO, p4);
	endtask

	// Mostly short periods so that dispatches are frequent; now and then a long one.
	task automatic randomize_config;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			write_reg(REG_TICK_PERIOD, $urandom_range(0, 6));
		else if (sel < 8)
			write_reg(REG_TICK_PERIOD, $urandom_range(7, 40));
		else if (sel == 8)
			write_reg(REG_TICK_PERIOD, PERIOD_MAX);
		else
			write_reg(REG_TICK_PERIOD, $urandom_range(0, PERIOD_MAX));
		// Narrow priority sets make ties and idle wins common.
		for (int k = 0; k < MAX_TASKS; k++) begin
			if ($urandom_range(0, 1))
				write_reg(3'(REG_IDLE_PRIO + k), $urandom_range(0, 3));
			else
				write_reg(3'(REG_IDLE_PRIO + k), $urandom_range(0, 255));
		end
	endtask

	// Defaults after reset: the first tick dispatches, later ones wait on the period.
	task automatic test_reset_defaults;
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		drain;
	endtask

	// Dispatch choice: ties, idle holding, priority extremes, ignored registers.
	task automatic test_dispatch_rules;
		write_reg(REG_TICK_PERIOD, 0);
		write_prios(255, 7, 7, 7, 7);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		drain;
		write_prios(0, 255, 255, 255, 255);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		drain;
		write_prios(255, 0, 0, 255, 0);
		send_tick(1'b1);
		send_tick(1'b1);
		drain;
		write_reg(REG_SPARE6, 32'hFFFF_FFFF);
		write_reg(REG_SPARE7, 32'h0000_0000);
		send_tick(1'b1);
		drain;
	endtask

	// Period extremes and a period lowered below the running count.
	task automatic test_period_changes;
		write_reg(REG_TICK_PERIOD, 1);
		send_tick(1'b1);
		send_tick(1'b1);
		drain;
		write_reg(REG_TICK_PERIOD, PERIOD_MAX);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		drain;
		write_reg(REG_TICK_PERIOD, 2);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		drain;
	endtask

	// Random ticks under one idling setting, with a new configuration every so often.
	task automatic test_random(input int send_pct, input int stall_pct, input int count);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		randomize_config;
		for (int i = 0; i < count; i++) begin
			if (i > 0 && i % 120 == 0) begin
				drain;
				randomize_config;
			end
			send_tick($urandom_range(0, 99) < 85);
		end
		drain;
	endtask

	// The result side holds off while ticks keep coming, then the result side stalls at random.
	task automatic test_backpressure;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_reg(REG_TICK_PERIOD, 0);
		hold_off = 300;
		for (int i = 0; i < 12; i++)
			send_tick($urandom_range(0, 3) != 0);
		drain;
		recv_stall_pct = 50;
		for (int i = 0; i < 12; i++)
			send_tick(1'b1);
		drain;
	endtask

	// Idle always wins, so every task ages on each dispatch.
	task automatic test_idle_aging;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_reg(REG_TICK_PERIOD, 0);
		write_prios(0, 1, 2, 3, 255);
		for (int i = 0; i < 40; i++)
			send_tick(1'b1);
		drain;
		// With idle out of the way, age and then priority decide.
		write_prios(255, 5, 5, 9, 5);
		send_tick(1'b1);
		send_tick(1'b1);
		drain;
		write_prios(255, 5, 5, 9, 5);
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.tick  <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults;
		test_dispatch_rules;
		test_period_changes;
		test_random(0, 0, 330);
		test_random(86, 0, 330);
		test_random(0, 86, 330);
		test_random(10, 10, 330);
		test_backpressure;
		test_idle_aging;

		// Leave room for any stray result transaction to show up.
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
